// File: rtl/dshr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dshr_pkg;

  localparam int MAX_POINTS_DEF = 4096;

  localparam int DIST_W = 48;
  localparam int SP_W   = 27;
  localparam int MG_W   = 28;
  localparam int DPR_W  = 16;
  localparam int HD_W   = 16;
  localparam int SD_W   = 47;
  localparam int CFG_W  = 28;

  localparam logic [DPR_W-1:0] DPR_RST = 16'd329;
  localparam logic [SP_W-1:0]  SP_RST  = 27'd2097152;
  localparam logic [MG_W-1:0]  FM_RST  = 28'd31457280;
  localparam logic [MG_W-1:0]  SM_RST  = 28'd52428800;

  localparam logic [1:0] CFG_DPR = 2'd0;
  localparam logic [1:0] CFG_SP  = 2'd1;
  localparam logic [1:0] CFG_FM  = 2'd2;
  localparam logic [1:0] CFG_SM  = 2'd3;

  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_RECORD = 3'd1;
  localparam logic [2:0] REQ_START  = 3'd2;
  localparam logic [2:0] REQ_TICK   = 3'd3;
  localparam logic [2:0] REQ_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_TRAVEL, S_DISPATCH, S_END, S_MARGIN, S_SELECT,
    S_DIV, S_CHECK, S_RDWAIT, S_REC, S_RESULT
  } state_t;

  function automatic logic [DIST_W-1:0] sat49(input logic [DIST_W:0] v);
    logic [DIST_W-1:0] r;
    if (v[DIST_W] != v[DIST_W-1]) begin
      r = v[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      r = v[DIST_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/distance_spaced_heading_recorder.sv
`timescale 1ns / 1ps
`default_nettype none
// Clear, replay start on an empty store and idle replay ticks pass S_TRAVEL and S_DISPATCH straight to S_RESULT.
// Record tick: S_REC stores points in turn, up to MAX_POINTS, one store write each.
// Replay tick with lookup and segment query of nonzero length pass S_END, S_MARGIN, S_SELECT and the 49-step divider.
// One word in work at a time; the next is taken while a result word waits in the output register.
// Reset (synchronous, active high): registers to defaults, all totals zero, store contents kept.
module distance_spaced_heading_recorder #(
  parameter int MAX_POINTS = dshr_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [1:0]                            cfg_index,
  input  wire logic [dshr_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic                                  req_valid,
  output logic                                       req_stall,
  input  wire logic [2:0]                            req_type,
  input  wire logic signed [15:0]                    left_wheel_rpm,
  input  wire logic signed [15:0]                    right_wheel_rpm,
  input  wire logic signed [15:0]                    heading_in,
  input  wire logic [dshr_pkg::SD_W-1:0]             segment_distance,
  input  wire logic [11:0]                           segment_start,
  input  wire logic [12:0]                           segment_length,
  output logic                                       res_valid,
  input  wire logic                                  res_stall,
  output logic signed [15:0]                         heading_out,
  output logic [1:0]                                 status,
  output logic                                       replay_done,
  output logic [$clog2(MAX_POINTS+1)-1:0]            stored_points,
  output logic signed [dshr_pkg::DIST_W-1:0]         total_distance
);
  import dshr_pkg::*;

  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = (PW > 13) ? PW : 13;
  localparam int EW = NW + SP_W;
  localparam int IW = (PW > 14) ? PW : 14;
  localparam int QW = SD_W + 2;
  localparam int VW = SP_W + 1;

  logic [DPR_W-1:0] dpr;
  logic [SP_W-1:0]  psp;
  logic [MG_W-1:0]  fmg;
  logic [MG_W-1:0]  smg;

  always_ff @(posedge clk) begin
    if (rst) begin
      dpr <= DPR_RST;
      psp <= SP_RST;
      fmg <= FM_RST;
      smg <= SM_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DPR: dpr <= cfg_data[DPR_W-1:0];
        CFG_SP:  psp <= cfg_data[SP_W-1:0];
        CFG_FM:  fmg <= cfg_data[MG_W-1:0];
        CFG_SM:  smg <= cfg_data[MG_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  logic [2:0]        rq;
  logic [15:0]       lw, rw, hd;
  logic [SD_W-1:0]   sdist;
  logic [11:0]       sstart;
  logic [12:0]       slen;

  logic [PW-1:0]         pt;
  logic [DIST_W-1:0]     acc;
  logic [DIST_W-1:0]     dt;
  logic [SD_W-1:0]       rd;
  logic [HD_W-1:0]       target;
  logic                  fin;

  logic signed [33:0]    prod;
  logic [EW-1:0]         end_d;
  logic [EW:0]           stop_d;
  logic [EW-1:0]         frz_d;
  logic [IW-1:0]         idx;
  logic [HD_W-1:0]       hres;
  logic [1:0]            sres;

  logic [SP_W-1:0]       sp;
  logic signed [16:0]    wsum;
  logic signed [32:0]    delta;
  logic [32:0]           absd;
  logic [DIST_W:0]       dt_sum, acc_sum;
  logic [DIST_W-1:0]     rd_sum;
  logic [SD_W-1:0]       rd_sat;
  logic [NW-1:0]         n_minus;
  logic                  acc_ge;
  logic                  at_stop, in_lookup;
  logic [SD_W-1:0]       qdist;
  logic [SD_W-1:0]       dval;
  logic [QW-1:0]         quot;
  logic                  div_done, div_start;
  logic [12:0]           off;
  logic [AW-1:0]         ridx;
  logic                  idx_ok;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [HD_W-1:0]       rdata;
  logic                  accept, res_free;

  assign accept   = req_valid && !req_stall;
  assign res_free = !res_valid || !res_stall;
  assign req_stall = (state != S_IDLE);

  assign sp      = (psp == '0) ? SP_W'(1) : psp;
  assign wsum    = $signed({lw[15], lw}) + $signed({rw[15], rw});
  assign delta   = prod[33:1];
  assign absd    = delta[32] ? 33'(-delta) : 33'(delta);
  assign dt_sum  = {dt[DIST_W-1], dt} + {{16{delta[32]}}, delta};
  assign acc_sum = {acc[DIST_W-1], acc} + {{16{delta[32]}}, delta};
  assign rd_sum  = {1'b0, rd} + DIST_W'(absd);
  assign rd_sat  = rd_sum[DIST_W-1] ? {SD_W{1'b1}} : rd_sum[SD_W-1:0];
  assign n_minus = ((rq == REQ_TICK) ? NW'(pt) : NW'(slen)) - NW'(1);
  assign acc_ge  = !acc[DIST_W-1] && (acc[DIST_W-2:0] >= (DIST_W-1)'(sp));
  assign at_stop   = {1'b0, rd} >= DIST_W'(stop_d);
  assign in_lookup = {1'b0, rd} < DIST_W'(frz_d);
  assign qdist   = (sdist > SD_W'(frz_d)) ? SD_W'(frz_d) : sdist;
  assign dval    = (rq == REQ_TICK) ? rd : qdist;
  assign off     = (quot >= QW'(slen)) ? (slen - 13'd1) : quot[12:0];
  assign ridx    = (quot >= QW'(pt)) ? AW'(pt - PW'(1)) : quot[AW-1:0];
  assign idx_ok  = idx < IW'(pt);

  dshr_div #(.NW(QW), .DW(VW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (QW'({dval, 1'b0}) + QW'(sp)),
    .den   ({sp, 1'b0}),
    .done  (div_done),
    .quot  (quot)
  );

  dshr_store #(.AW(AW), .DW(HD_W)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pt[AW-1:0]),
    .wdata (hd),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    div_start  = 1'b0;
    case (state)
      S_IDLE:   if (accept) state_next = S_TRAVEL;
      S_TRAVEL: state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (rq)
          REQ_RECORD: state_next = S_REC;
          REQ_START: begin
            if (pt != '0) begin
              mem_re     = 1'b1;
              state_next = S_RDWAIT;
            end else begin
              state_next = S_RESULT;
            end
          end
          REQ_TICK:  state_next = (!fin && pt != '0) ? S_END : S_RESULT;
          REQ_QUERY: state_next = (slen == '0) ? S_CHECK : S_END;
          default:   state_next = S_RESULT;
        endcase
      end
      S_END:    state_next = S_MARGIN;
      S_MARGIN: state_next = S_SELECT;
      S_SELECT: begin
        if (rq != REQ_TICK || in_lookup) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (rq == REQ_TICK) begin
            mem_re     = 1'b1;
            mem_raddr  = ridx;
            state_next = S_RDWAIT;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (idx_ok) begin
          mem_re     = 1'b1;
          mem_raddr  = idx[AW-1:0];
          state_next = S_RDWAIT;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_RDWAIT: state_next = S_RESULT;
      S_REC: begin
        if (acc_ge && pt < PW'(MAX_POINTS)) begin
          mem_we = 1'b1;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: if (res_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt        <= '0;
      acc       <= '0;
      dt        <= '0;
      rd        <= '0;
      target    <= '0;
      fin       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (state == S_RESULT && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rq     <= req_type;
            lw     <= left_wheel_rpm;
            rw     <= right_wheel_rpm;
            hd     <= heading_in;
            sdist  <= segment_distance;
            sstart <= segment_start;
            slen   <= segment_length;
          end
        end
        S_TRAVEL: prod <= wsum * $signed({1'b0, dpr});
        S_DISPATCH: begin
          sres <= ST_OK;
          hres <= target;
          case (rq)
            REQ_CLEAR: begin
              pt     <= '0;
              acc    <= '0;
              dt     <= '0;
              rd     <= '0;
              target <= '0;
              fin    <= 1'b0;
              hres   <= '0;
            end
            REQ_RECORD: begin
              dt  <= sat49(dt_sum);
              acc <= sat49(acc_sum);
            end
            REQ_START: begin
              rd  <= '0;
              fin <= (pt == '0);
              if (pt == '0) begin
                target <= '0;
                hres   <= '0;
              end
            end
            REQ_TICK: if (!fin && pt != '0) rd <= rd_sat;
            REQ_QUERY: idx <= IW'(sstart);
            default: ;
          endcase
        end
        S_END: end_d <= EW'(n_minus * sp);
        S_MARGIN: begin
          stop_d <= {1'b0, end_d} + (EW+1)'(smg);
          frz_d  <= (end_d > EW'(fmg)) ? (end_d - EW'(fmg)) : '0;
        end
        S_SELECT: if (rq == REQ_TICK && at_stop) fin <= 1'b1;
        S_DIV: if (div_done && rq != REQ_TICK) idx <= IW'(sstart) + IW'(off);
        S_CHECK: begin
          if (!idx_ok) begin
            hres <= '0;
            sres <= ST_OVERRUN;
          end
        end
        S_RDWAIT: begin
          hres <= rdata;
          if (rq != REQ_QUERY) target <= rdata;
        end
        S_REC: begin
          if (acc_ge) begin
            if (pt < PW'(MAX_POINTS)) begin
              pt  <= pt + PW'(1);
              acc <= acc - DIST_W'(sp);
            end else begin
              sres <= ST_FULL;
            end
          end
        end
        S_RESULT: begin
          if (res_free) begin
            heading_out    <= hres;
            status         <= sres;
            replay_done    <= fin;
            stored_points  <= pt;
            total_distance <= dt;
          end
        end
        default: ;
      endcase
    end
  end

  a_pt_bound: assert property (@(posedge clk) disable iff (rst)
    pt <= PW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_REC && pt < PW'(MAX_POINTS) && acc_ge))
    else $error("store write outside record loop");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_TRAVEL)
    else $error("accepted word not taken into work");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished while not awaited");

endmodule
`default_nettype wire

// File: rtl/dshr_store.sv
`timescale 1ns / 1ps
`default_nettype none
module dshr_store #(
  parameter int AW = 12,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1<<AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/dshr_div.sv
`timescale 1ns / 1ps
`default_nettype none
module dshr_div #(
  parameter int NW = 49,
  parameter int DW = 28
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic          ge;

  assign shifted = {rem, quot[NW-1]};
  assign ge      = shifted >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        rem  <= '0;
        quot <= num;
        dv   <= den;
      end else if (busy) begin
        rem  <= ge ? DW'(shifted - {1'b0, dv}) : shifted[DW-1:0];
        quot <= {quot[NW-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/distance_spaced_heading_recorder_tb.sv
`timescale 1ns / 1ps
module distance_spaced_heading_recorder_tb;
  import dshr_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;
  localparam longint DMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint DMIN = -DMAX - 1;
  localparam int WD_LIMIT = 200000;

  typedef struct packed {
    logic signed [15:0] heading;
    logic [1:0]         stat;
    logic               done;
    logic [12:0]        points;
    logic signed [47:0] total;
  } result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = CFG_DPR;
  logic [CFG_W-1:0] cfg_data = '0;
  logic req_valid = 0;
  logic req_stall;
  logic [2:0] req_type = REQ_CLEAR;
  logic signed [15:0] left_wheel_rpm = 0, right_wheel_rpm = 0, heading_in = 0;
  logic [SD_W-1:0] segment_distance = '0;
  logic [11:0] segment_start = '0;
  logic [12:0] segment_length = '0;
  logic res_valid;
  logic res_stall = 1;
  logic signed [15:0] heading_out;
  logic [1:0] status;
  logic replay_done;
  logic [12:0] stored_points;
  logic signed [47:0] total_distance;

  distance_spaced_heading_recorder dut (.*);

  initial forever #1 clk = ~clk;

  // predictor state
  longint unsigned m_dpr, m_sp, m_fm, m_sm;
  logic [15:0] m_store [NPTS];
  int unsigned m_pts;
  longint m_acc, m_tot, m_rdist;
  logic [15:0] m_tgt;
  logic m_fin;

  result_t pending[$];
  int errors = 0, n_sent = 0, n_got = 0, idle_cnt = 0, hold_cycles = 0;
  bit rx_rand = 1;

  function automatic longint travel(logic signed [15:0] l, logic signed [15:0] r);
    longint p;
    p = (longint'(l) + longint'(r)) * longint'(m_dpr);
    return (p >>> 1);
  endfunction

  function automatic longint sat48(longint v);
    if (v > DMAX) return DMAX;
    if (v < DMIN) return DMIN;
    return v;
  endfunction

  function automatic longint unsigned near_idx(longint unsigned d, longint unsigned sp);
    return (2 * d + sp) / (2 * sp);
  endfunction

  function automatic result_t predict_word(logic [2:0] t, logic signed [15:0] l,
      logic signed [15:0] r, logic [15:0] h, logic [46:0] sd, logic [11:0] ss,
      logic [12:0] sl);
    result_t o;
    longint unsigned sp, e, stp, frz, rd, idx, q;
    longint d;
    sp = (m_sp == 0) ? 1 : m_sp;
    o.heading = m_tgt;
    o.stat = ST_OK;
    case (t)
      REQ_CLEAR: begin
        m_pts = 0; m_acc = 0; m_tot = 0; m_rdist = 0; m_tgt = 0; m_fin = 0;
        o.heading = 0;
      end
      REQ_RECORD: begin
        d = travel(l, r);
        m_tot = sat48(m_tot + d);
        m_acc = sat48(m_acc + d);
        while (m_acc >= longint'(sp)) begin
          if (m_pts >= NPTS) begin
            o.stat = ST_FULL;
            break;
          end
          m_store[m_pts] = h;
          m_pts++;
          m_acc -= longint'(sp);
        end
      end
      REQ_START: begin
        m_rdist = 0; m_fin = 0;
        if (m_pts > 0) m_tgt = m_store[0];
        else begin
          m_tgt = 0; m_fin = 1;
        end
        o.heading = m_tgt;
      end
      REQ_TICK: begin
        if (!m_fin && m_pts > 0) begin
          d = travel(l, r);
          if (d < 0) d = -d;
          m_rdist += d;
          if (m_rdist > DMAX) m_rdist = DMAX;
          rd = m_rdist;
          e = longint'(m_pts - 1) * sp;
          stp = e + m_sm;
          frz = (e > m_fm) ? e - m_fm : 0;
          if (rd < frz) begin
            idx = near_idx(rd, sp);
            if (idx >= m_pts) idx = m_pts - 1;
            m_tgt = m_store[idx];
          end
          if (rd >= stp) m_fin = 1;
        end
        o.heading = m_tgt;
      end
      REQ_QUERY: begin
        if (sl == 0) idx = ss;
        else begin
          e = longint'(sl - 1) * sp;
          frz = (e > m_fm) ? e - m_fm : 0;
          q = (sd > frz) ? frz : sd;
          idx = near_idx(q, sp);
          if (idx >= sl) idx = sl - 1;
          idx += ss;
        end
        if (idx < m_pts) o.heading = m_store[idx];
        else begin
          o.heading = 0; o.stat = ST_OVERRUN;
        end
      end
      default: ;
    endcase
    o.done = m_fin;
    o.points = m_pts[12:0];
    o.total = m_tot[47:0];
    return o;
  endfunction

  task automatic send_word(logic [2:0] t, logic signed [15:0] l, logic signed [15:0] r,
      logic signed [15:0] h, logic [46:0] sd = 0, logic [11:0] ss = 0,
      logic [12:0] sl = 0, bit gaps = 1);
    int g;
    g = gaps ? $urandom_range(0, 13) : 0;
    if (gaps && $urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      req_valid <= 0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1; req_type <= t; left_wheel_rpm <= l; right_wheel_rpm <= r;
    heading_in <= h; segment_distance <= sd; segment_start <= ss; segment_length <= sl;
    do @(posedge clk); while (req_stall);
    pending.push_back(predict_word(t, l, r, h, sd, ss, sl));
    n_sent++;
  endtask

  task automatic drain();
    req_valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] i, longint unsigned v);
    drain();
    cfg_write <= 1; cfg_index <= i; cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 0;
    case (i)
      CFG_DPR: m_dpr = v & 16'hFFFF;
      CFG_SP:  m_sp = v & 27'h7FF_FFFF;
      CFG_FM:  m_fm = v & 28'hFFF_FFFF;
      default: m_sm = v & 28'hFFF_FFFF;
    endcase
  endtask

  function automatic logic [2:0] rand_req();
    int k;
    k = $urandom_range(0, 99);
    if (k < 2) return REQ_CLEAR;
    if (k < 40) return REQ_RECORD;
    if (k < 45) return REQ_START;
    if (k < 80) return REQ_TICK;
    if (k < 98) return REQ_QUERY;
    return 3'($urandom_range(5, 7));
  endfunction

  task automatic rand_word(bit gaps = 1);
    logic [2:0] t;
    logic signed [15:0] l, r;
    t = rand_req();
    l = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
    r = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
    send_word(t, l, r, 16'($urandom), {15'($urandom), 32'($urandom)} >>
      $urandom_range(0, 46), 12'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)),
      13'($urandom_range(0, 3) == 0 ? $urandom_range(0, 4096) : $urandom_range(0, 20)), gaps);
  endtask

  task automatic test_directed();
    send_word(REQ_START, 0, 0, 0);
    send_word(REQ_TICK, 100, 100, 0);
    send_word(REQ_QUERY, 0, 0, 0, 0, 0, 0);
    send_word(REQ_RECORD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_word(REQ_RECORD, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(REQ_RECORD, -1, 0, 16'sh1234);
    send_word(REQ_RECORD, 16'sh7FFF, 16'sh7FFF, -16'sd1);
    send_word(REQ_RECORD, 16'sh7FFF, 16'sh7FFF, 16'sh5555);
    send_word(REQ_QUERY, 0, 0, 0, 47'h7FFF_FFFF_FFFF, 0, 13'd4096);
    send_word(REQ_QUERY, 0, 0, 0, 0, 12'hFFF, 0);
    send_word(REQ_QUERY, 0, 0, 0, 47'd3_000_000, 1, 3);
    send_word(REQ_START, 0, 0, 0);
    repeat (6) send_word(REQ_TICK, 16'sh8000, 16'sh8000, 0);
    send_word(3'd5, 1, 1, 1);
    send_word(3'd7, 1, 1, 1);
    send_word(REQ_CLEAR, 0, 0, 0);
  endtask

  task automatic test_settings();
    set_reg(CFG_SP, 0);
    set_reg(CFG_DPR, 16'hFFFF);
    repeat (3) send_word(REQ_RECORD, 1, 0, 16'($urandom));
    send_word(REQ_QUERY, 0, 0, 0, 47'd1, 0, 4);
    send_word(REQ_CLEAR, 0, 0, 0);
    set_reg(CFG_SP, 67108864);
    set_reg(CFG_FM, 0);
    set_reg(CFG_SM, 0);
    repeat (40) rand_word();
    set_reg(CFG_FM, 134217728);
    set_reg(CFG_SM, 134217728);
    set_reg(CFG_DPR, 0);
    repeat (20) rand_word();
    set_reg(CFG_DPR, 329);
    set_reg(CFG_SP, 2097152);
    set_reg(CFG_FM, 31457280);
    set_reg(CFG_SM, 52428800);
  endtask

  task automatic test_store_full();
    set_reg(CFG_SP, 8192);
    set_reg(CFG_DPR, 16'hFFFF);
    send_word(REQ_CLEAR, 0, 0, 0);
    // the first full-speed tick fills the store, the rest report full
    repeat (3) send_word(REQ_RECORD, 16'sh7FFF, 16'sh7FFF, 16'($urandom));
    send_word(REQ_QUERY, 0, 0, 0, 0, 12'hFFF, 0);
    send_word(REQ_QUERY, 0, 0, 0, 47'h7FFF_FFFF_FFFF, 12'd100, 13'd4096);
    send_word(REQ_START, 0, 0, 0);
    repeat (10) send_word(REQ_TICK, 16'($urandom), 16'($urandom), 0);
    send_word(REQ_CLEAR, 0, 0, 0);
    set_reg(CFG_SP, 2097152);
    set_reg(CFG_DPR, 329);
  endtask

  task automatic test_teach_repeat(int rounds);
    int n;
    repeat (rounds) begin
      send_word(REQ_CLEAR, 0, 0, 0);
      n = $urandom_range(5, 40);
      repeat (n) send_word(REQ_RECORD, 16'($urandom_range(500, 9000)),
        16'($urandom_range(500, 9000)), 16'($urandom));
      send_word(REQ_START, 0, 0, 0);
      repeat (n + 20) send_word(REQ_TICK, 16'($urandom_range(0, 9000)),
        -16'($urandom_range(0, 9000)), 0);
      repeat (5) rand_word();
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (30) rand_word(0);
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (!rst && res_valid && !res_stall) begin
      n_got <= n_got + 1;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word heading %0d", $time, heading_out);
        errors++;
      end else begin
        e = pending.pop_front();
        if (heading_out !== e.heading) begin
          $display("%0t: heading exp %0d got %0d", $time, e.heading, heading_out); errors++;
        end
        if (status !== e.stat) begin
          $display("%0t: status exp %0d got %0d", $time, e.stat, status); errors++;
        end
        if (replay_done !== e.done) begin
          $display("%0t: done exp %0d got %0d", $time, e.done, replay_done); errors++;
        end
        if (stored_points !== e.points) begin
          $display("%0t: points exp %0d got %0d", $time, e.points, stored_points); errors++;
        end
        if (total_distance !== e.total) begin
          $display("%0t: total exp %0d got %0d", $time, e.total, total_distance); errors++;
        end
      end
    end
  end

  // receiver stall
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        res_stall <= 1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = rx_rand ? $urandom_range(0, 13) : 0;
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w != 0) begin
        res_stall <= 1;
        repeat (w) @(posedge clk);
      end
      res_stall <= 0;
      @(posedge clk);
      while (!res_valid && hold_cycles == 0) @(posedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall) || rst) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("distance_spaced_heading_recorder verification failed");
      $finish;
    end
  end

  initial begin
    m_dpr = 329; m_sp = 2097152; m_fm = 31457280; m_sm = 52428800;
    m_pts = 0; m_acc = 0; m_tot = 0; m_rdist = 0; m_tgt = 0; m_fin = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_settings();
    test_store_full();
    test_teach_repeat(6);
    test_backpressure();
    repeat (500) rand_word();
    drain();
    repeat (100) rand_word();
    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d words, checked %0d results over record, replay, query and clear,",
      n_sent, n_got);
    $display("with register extremes, store full and output back-pressure.");
    if (errors == 0 && pending.size() == 0) begin
      $display("distance_spaced_heading_recorder verification clean");
    end else begin
      $display("distance_spaced_heading_recorder verification failed");
    end
    $finish;
  end
endmodule
